// File: rtl/rmat_pkg.sv
// Shared widths, register indexes, edge kinds and the queued edge type.
`timescale 1ns / 1ps
package rmat_pkg;

  // Field widths fixed by the interface
  localparam int FRAC_W     = 32;
  localparam int PROB_W     = 33;
  localparam int LEVELS_W   = 5;
  localparam int SPATIAL_W  = 21;
  localparam int OUT_W      = 20;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;
  localparam int AB_W       = PROB_W + 1;
  localparam int ABC_W      = PROB_W + 2;

  // Edge queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [KIND_W-1:0]    kind_t;

  // Register indexes
  localparam cfg_idx_t CFG_PROB_A  = 3'd0;
  localparam cfg_idx_t CFG_PROB_B  = 3'd1;
  localparam cfg_idx_t CFG_PROB_C  = 3'd2;
  localparam cfg_idx_t CFG_LEVELS  = 3'd3;
  localparam cfg_idx_t CFG_SPATIAL = 3'd4;

  // Edge kinds
  localparam kind_t KIND_FRIEND  = 3'd0;
  localparam kind_t KIND_VISIT   = 3'd2;
  localparam kind_t KIND_VISITED = 3'd4;
  localparam kind_t KIND_SIMILAR = 3'd6;

  // Register reset values, with the threshold sums they imply
  localparam logic [PROB_W-1:0]    PROB_A_RST  = 33'd2448131359;
  localparam logic [PROB_W-1:0]    PROB_B_RST  = 33'd816043786;
  localparam logic [PROB_W-1:0]    PROB_C_RST  = 33'd816043786;
  localparam logic [AB_W-1:0]      AB_RST      = 34'd3264175145;
  localparam logic [ABC_W-1:0]     ABC_RST     = 35'd4080218931;
  localparam logic [LEVELS_W-1:0]  LEVELS_RST  = 5'd20;
  localparam logic [SPATIAL_W-1:0] SPATIAL_RST = 21'd524288;

  // One finished, non-looping edge
  typedef struct packed {
    logic [OUT_W-1:0] src;
    logic [OUT_W-1:0] dst;
    logic             src_sp;
    logic             dst_sp;
  } edge_t;

  // Kind of an entry from the spatial flags of its two endpoints
  function automatic kind_t kind_of(input logic s_sp, input logic d_sp);
    kind_t k;
    if (s_sp) begin
      k = d_sp ? KIND_SIMILAR : KIND_VISITED;
    end else begin
      k = d_sp ? KIND_VISIT : KIND_FRIEND;
    end
    return k;
  endfunction

endpackage

// File: rtl/rmat_in_if.sv
// Input channel: one random fraction per item.
`timescale 1ns / 1ps
interface rmat_in_if import rmat_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] rand_fraction;

  modport source (output valid, output rand_fraction, input ready);
  modport sink   (input valid, input rand_fraction, output ready);
endinterface

// File: rtl/rmat_out_if.sv
// Result channel: one adjacency entry per item.
`timescale 1ns / 1ps
interface rmat_out_if import rmat_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  src_node;
  logic [OUT_W-1:0]  dst_node;
  logic [KIND_W-1:0] edge_kind;
  logic              last;

  modport source (output valid, output src_node, output dst_node, output edge_kind,
                  output last, input ready);
  modport sink   (input valid, input src_node, input dst_node, input edge_kind,
                  input last, output ready);
endinterface

// File: rtl/rmat_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface rmat_cfg_if import rmat_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/rmat_typed_edge_generator.sv
// Top level of the R-MAT typed edge generator.
// Takes one random fraction per cycle; no input stall while the edge queue has room.
// An edge completes on the fraction of its last level, passes the edge queue and the
// output register, and its reverse entry follows once the forward one has been taken.
// Output is two entries per edge. Synchronous active-low reset clears the level walk, the
// queue and the output stage, and loads the register defaults.
`timescale 1ns / 1ps
module rmat_typed_edge_generator import rmat_pkg::*; #(
  parameter int NODE_BITS = 20
) (
  input  logic clk,
  input  logic rst_n,
  rmat_in_if.sink    in_ch,
  rmat_out_if.source out_ch,
  rmat_cfg_if.sink   cfg_ch
);

  logic  q_push, q_full, q_pop, q_empty;
  edge_t q_data, q_head;

  // Accept fractions and assemble edges
  rmat_front #(.NODE_BITS(NODE_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // Hold finished edges
  rmat_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Emit entry pairs
  rmat_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/rmat_front.sv
// Front end: config registers, quadrant pick per level and edge assembly.
`timescale 1ns / 1ps
module rmat_front import rmat_pkg::*; #(
  parameter int NODE_BITS = 20
) (
  input  logic   clk,
  input  logic   rst_n,
  rmat_in_if.sink  in_ch,
  rmat_cfg_if.sink cfg_ch,
  input  logic   q_full,
  output logic   q_push,
  output edge_t  q_data
);

  localparam int LVL_W   = $clog2(NODE_BITS + 1);
  localparam int CLAMP_W = (LVL_W > LEVELS_W) ? LVL_W : LEVELS_W;
  localparam int CMP_W   = (NODE_BITS > SPATIAL_W) ? NODE_BITS : SPATIAL_W;

  logic [PROB_W-1:0]    prob_a_r, prob_a_nxt;
  logic [PROB_W-1:0]    prob_b_r, prob_b_nxt;
  logic [PROB_W-1:0]    prob_c_r, prob_c_nxt;
  logic [AB_W-1:0]      ab_r, ab_nxt;
  logic [ABC_W-1:0]     abc_r, abc_nxt;
  logic [LEVELS_W-1:0]  levels_r, levels_nxt;
  logic [SPATIAL_W-1:0] spatial_r, spatial_nxt;

  logic [LVL_W-1:0]     lc_r, lc_nxt;
  logic [NODE_BITS-1:0] row_r, row_nxt;
  logic [NODE_BITS-1:0] col_r, col_nxt;

  logic [CLAMP_W-1:0]   lv_ext, lv_eff;
  logic [LVL_W-1:0]     depth, lc_cur, lc_inc, pos;
  logic [NODE_BITS-1:0] row_cur, col_cur, bit_mask, row_new, col_new;
  logic [ABC_W-1:0]     frac;
  logic                 restart, row_set, col_set, done, accept;

  assign cfg_ch.ready = 1'b1;

  // Register writes; keep the threshold sums in step with the probabilities
  always_comb begin
    prob_a_nxt  = prob_a_r;
    prob_b_nxt  = prob_b_r;
    prob_c_nxt  = prob_c_r;
    ab_nxt      = ab_r;
    abc_nxt     = abc_r;
    levels_nxt  = levels_r;
    spatial_nxt = spatial_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PROB_A: begin
          prob_a_nxt = PROB_W'(cfg_ch.data);
          ab_nxt     = AB_W'(cfg_ch.data) + AB_W'(prob_b_r);
          abc_nxt    = ABC_W'(cfg_ch.data) + ABC_W'(prob_b_r) + ABC_W'(prob_c_r);
        end
        CFG_PROB_B: begin
          prob_b_nxt = PROB_W'(cfg_ch.data);
          ab_nxt     = AB_W'(prob_a_r) + AB_W'(cfg_ch.data);
          abc_nxt    = ABC_W'(prob_a_r) + ABC_W'(cfg_ch.data) + ABC_W'(prob_c_r);
        end
        CFG_PROB_C: begin
          prob_c_nxt = PROB_W'(cfg_ch.data);
          abc_nxt    = ABC_W'(prob_a_r) + ABC_W'(prob_b_r) + ABC_W'(cfg_ch.data);
        end
        CFG_LEVELS:  levels_nxt  = LEVELS_W'(cfg_ch.data);
        CFG_SPATIAL: spatial_nxt = SPATIAL_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Clamp depth to one through NODE_BITS
  always_comb begin
    lv_ext = CLAMP_W'(levels_r);
    if (lv_ext == '0) begin
      lv_eff = CLAMP_W'(1);
    end else if (lv_ext > CLAMP_W'(NODE_BITS)) begin
      lv_eff = CLAMP_W'(NODE_BITS);
    end else begin
      lv_eff = lv_ext;
    end
    depth = LVL_W'(lv_eff);
  end

  // Quadrant: thresholds are ordered, so two bits fall out of three compares
  assign frac    = ABC_W'(in_ch.rand_fraction);
  assign row_set = frac >= ABC_W'(ab_r);
  assign col_set = (frac >= ABC_W'(prob_a_r) && frac < ABC_W'(ab_r)) || frac >= abc_r;

  // Drop a partial edge left over from a deeper setting
  assign restart = lc_r >= depth;
  assign lc_cur  = restart ? '0 : lc_r;
  assign row_cur = restart ? '0 : row_r;
  assign col_cur = restart ? '0 : col_r;

  // Set this level's bit, most significant level first
  assign pos      = depth - LVL_W'(1) - lc_cur;
  assign bit_mask = NODE_BITS'(1) << pos;
  assign row_new  = row_cur | (row_set ? bit_mask : '0);
  assign col_new  = col_cur | (col_set ? bit_mask : '0);
  assign lc_inc   = lc_cur + LVL_W'(1);
  assign done     = lc_inc == depth;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  // Push a finished edge unless it loops on itself
  assign q_push        = accept && done && (row_new != col_new);
  assign q_data.src    = OUT_W'(row_new);
  assign q_data.dst    = OUT_W'(col_new);
  assign q_data.src_sp = CMP_W'(row_new) >= CMP_W'(spatial_r);
  assign q_data.dst_sp = CMP_W'(col_new) >= CMP_W'(spatial_r);

  // Advance the level walk
  always_comb begin
    lc_nxt  = lc_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (done) begin
        lc_nxt  = '0;
        row_nxt = '0;
        col_nxt = '0;
      end else begin
        lc_nxt  = lc_inc;
        row_nxt = row_new;
        col_nxt = col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_a_r  <= PROB_A_RST;
      prob_b_r  <= PROB_B_RST;
      prob_c_r  <= PROB_C_RST;
      ab_r      <= AB_RST;
      abc_r     <= ABC_RST;
      levels_r  <= LEVELS_RST;
      spatial_r <= SPATIAL_RST;
      lc_r      <= '0;
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      prob_a_r  <= prob_a_nxt;
      prob_b_r  <= prob_b_nxt;
      prob_c_r  <= prob_c_nxt;
      ab_r      <= ab_nxt;
      abc_r     <= abc_nxt;
      levels_r  <= levels_nxt;
      spatial_r <= spatial_nxt;
      lc_r      <= lc_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

endmodule

// File: rtl/rmat_queue.sv
// Short edge queue between the front end and the entry emitter.
`timescale 1ns / 1ps
module rmat_queue import rmat_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  edge_t push_data,
  output logic  full,
  input  logic  pop,
  output edge_t head,
  output logic  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  edge_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed edge
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/rmat_back.sv
// Back end: emits the forward and then the reverse entry of each edge.
`timescale 1ns / 1ps
module rmat_back import rmat_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  edge_t q_head,
  output logic  q_pop,
  rmat_out_if.source out_ch
);

  edge_t edge_r, edge_nxt;
  logic  valid_r, valid_nxt;
  logic  last_r, last_nxt;
  logic  take;

  assign take  = out_ch.valid && out_ch.ready;
  assign q_pop = !q_empty && (!valid_r || (take && last_r));

  // Load a new edge, flip to the reverse entry, or drain
  always_comb begin
    edge_nxt  = edge_r;
    valid_nxt = valid_r;
    last_nxt  = last_r;
    if (q_pop) begin
      edge_nxt  = q_head;
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
    end else if (take && !last_r) begin
      last_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r <= edge_nxt;
  end

  // Swap endpoints on the reverse entry
  assign out_ch.valid     = valid_r;
  assign out_ch.last      = last_r;
  assign out_ch.src_node  = last_r ? edge_r.dst : edge_r.src;
  assign out_ch.dst_node  = last_r ? edge_r.src : edge_r.dst;
  assign out_ch.edge_kind = last_r ? kind_of(edge_r.dst_sp, edge_r.src_sp)
                                   : kind_of(edge_r.src_sp, edge_r.dst_sp);

endmodule

// File: rtl/rmat_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module rmat_checker import rmat_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [OUT_W-1:0]  out_src_node,
  input logic [OUT_W-1:0]  out_dst_node,
  input logic [KIND_W-1:0] out_edge_kind,
  input logic              out_last
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Reverse entry follows the forward one with endpoints swapped
  a_reverse_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_last && out_src_node == $past(out_dst_node) &&
      out_dst_node == $past(out_src_node))
    else $error("reverse entry missing or not swapped");

  // Self-loops never reach the output
  a_no_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_src_node != out_dst_node)
    else $error("self-loop entry emitted");

  // Kinds are even codes
  a_kind_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_kind[0] == 1'b0)
    else $error("odd edge kind");

endmodule

bind rmat_typed_edge_generator rmat_checker u_rmat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_src_node  (out_ch.src_node),
  .out_dst_node  (out_ch.dst_node),
  .out_edge_kind (out_ch.edge_kind),
  .out_last      (out_ch.last)
);

// File: tb/sv/rmat_typed_edge_generator_test.sv
// Self-checking testbench for the R-MAT typed edge generator: directed and random tests.
`timescale 1ns / 1ps
module rmat_typed_edge_generator_test import rmat_pkg::*;;

  localparam int NODE_BITS     = 20;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam longint FRAC_MAX  = 64'h0000_0000_FFFF_FFFF;
  // Index outside the register map; writes to it must change nothing
  localparam cfg_idx_t CFG_UNUSED = 3'd7;

  // One adjacency entry as it leaves the block
  typedef struct packed {
    logic [OUT_W-1:0] src;
    logic [OUT_W-1:0] dst;
    kind_t            kind;
    logic             last;
  } adj_entry_t;

  logic clk;
  logic rst_n;

  rmat_in_if  in_ch ();
  rmat_out_if out_ch ();
  rmat_cfg_if cfg_ch ();

  rmat_typed_edge_generator #(
    .NODE_BITS(NODE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Register shadow and level walk of the edge predictor
  logic [PROB_W-1:0]    prob_a_q;
  logic [PROB_W-1:0]    prob_b_q;
  logic [PROB_W-1:0]    prob_c_q;
  logic [LEVELS_W-1:0]  levels_q;
  logic [SPATIAL_W-1:0] spatial_q;
  logic [4:0]           walk_level;
  logic [NODE_BITS-1:0] walk_row;
  logic [NODE_BITS-1:0] walk_col;

  adj_entry_t entries_due[$];
  adj_entry_t got_entry;
  adj_entry_t want_entry;

  int mismatches;
  int idle_cycles;
  int burst_left;
  int random_sent;
  int rx_mode;
  int rx_hold;
  logic [7:0] rx_mask;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Recursion depth actually used for a levels setting
  function automatic int walk_depth();
    int depth;
    depth = levels_q;
    if (depth < 1) depth = 1;
    if (depth > NODE_BITS) depth = NODE_BITS;
    return depth;
  endfunction

  function automatic kind_t entry_kind(input logic [NODE_BITS-1:0] src,
                                       input logic [NODE_BITS-1:0] dst);
    logic src_sp;
    logic dst_sp;
    src_sp = ({1'b0, src} >= spatial_q);
    dst_sp = ({1'b0, dst} >= spatial_q);
    if (src_sp && dst_sp) return KIND_SIMILAR;
    if (src_sp) return KIND_VISITED;
    if (dst_sp) return KIND_VISIT;
    return KIND_FRIEND;
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_frac(input longint v);
    if (v < 0) v = 0;
    if (v > FRAC_MAX) v = FRAC_MAX;
    return v[FRAC_W-1:0];
  endfunction

  // Fraction within one step of one of the three quadrant thresholds
  function automatic logic [FRAC_W-1:0] near_threshold();
    longint thr;
    case ($urandom_range(0, 2))
      0: thr = longint'(prob_a_q);
      1: thr = longint'(prob_a_q) + longint'(prob_b_q);
      default: thr = longint'(prob_a_q) + longint'(prob_b_q) + longint'(prob_c_q);
    endcase
    return clamp_frac(thr + longint'($urandom_range(0, 2)) - 1);
  endfunction

  function automatic logic [FRAC_W-1:0] random_fraction();
    if ($urandom_range(0, 9) < 3) return near_threshold();
    return $urandom;
  endfunction

  // Advance the level walk by one fraction; queue the entry pair of a finished edge
  task automatic advance_walk(input logic [FRAC_W-1:0] frac);
    longint frac_v;
    longint thr_ab;
    longint thr_abc;
    int depth;
    logic [NODE_BITS-1:0] level_bit;
    logic [NODE_BITS-1:0] row;
    logic [NODE_BITS-1:0] col;
    adj_entry_t fwd;
    adj_entry_t rev;
    frac_v  = longint'(frac);
    thr_ab  = longint'(prob_a_q) + longint'(prob_b_q);
    thr_abc = thr_ab + longint'(prob_c_q);
    depth   = walk_depth();
    // Drop a partial edge that the current depth has already passed
    if (int'(walk_level) >= depth) begin
      walk_level = '0;
      walk_row   = '0;
      walk_col   = '0;
    end
    level_bit = '0;
    level_bit[depth - 1 - int'(walk_level)] = 1'b1;
    if (frac_v >= longint'(prob_a_q) && frac_v < thr_ab) begin
      walk_col = walk_col | level_bit;
    end else if (frac_v >= thr_ab && frac_v < thr_abc) begin
      walk_row = walk_row | level_bit;
    end else if (frac_v >= thr_abc) begin
      walk_row = walk_row | level_bit;
      walk_col = walk_col | level_bit;
    end
    walk_level = walk_level + 5'd1;
    if (int'(walk_level) < depth) return;
    row = walk_row;
    col = walk_col;
    walk_level = '0;
    walk_row   = '0;
    walk_col   = '0;
    // Self-loops produce nothing
    if (row == col) return;
    fwd.src  = row[OUT_W-1:0];
    fwd.dst  = col[OUT_W-1:0];
    fwd.kind = entry_kind(row, col);
    fwd.last = 1'b0;
    rev.src  = col[OUT_W-1:0];
    rev.dst  = row[OUT_W-1:0];
    rev.kind = entry_kind(col, row);
    rev.last = 1'b1;
    entries_due.insert(entries_due.size(), fwd);
    entries_due.insert(entries_due.size(), rev);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Send one fraction in bursts with random gaps; returns at a falling edge
  task automatic send_fraction(input logic [FRAC_W-1:0] frac);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid         = 1'b1;
    in_ch.rand_fraction = frac;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    advance_walk(frac);
    @(negedge clk);
  endtask

  // Hold the sender until every queued entry has come out and the block has settled
  task automatic wait_for_drain();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (entries_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_PROB_A:  prob_a_q  = value[PROB_W-1:0];
      CFG_PROB_B:  prob_b_q  = value[PROB_W-1:0];
      CFG_PROB_C:  prob_c_q  = value[PROB_W-1:0];
      CFG_LEVELS:  levels_q  = value[LEVELS_W-1:0];
      CFG_SPATIAL: spatial_q = value[SPATIAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [PROB_W-1:0] a, input logic [PROB_W-1:0] b,
                                input logic [PROB_W-1:0] c, input logic [LEVELS_W-1:0] lv,
                                input logic [SPATIAL_W-1:0] sp);
    wait_for_drain();
    write_reg(CFG_PROB_A, a);
    write_reg(CFG_PROB_B, b);
    write_reg(CFG_PROB_C, c);
    write_reg(CFG_LEVELS, lv);
    write_reg(CFG_SPATIAL, sp);
  endtask

  // Fractions on both sides of each reset threshold, plus the field extremes
  task automatic test_threshold_boundaries();
    longint thr_ab;
    longint thr_abc;
    wait_for_drain();
    write_reg(CFG_LEVELS, 5'd3);
    write_reg(CFG_SPATIAL, 21'd4);
    thr_ab  = longint'(prob_a_q) + longint'(prob_b_q);
    thr_abc = thr_ab + longint'(prob_c_q);
    send_fraction(32'h0000_0000);
    send_fraction(32'hFFFF_FFFF);
    send_fraction(clamp_frac(longint'(prob_a_q) - 1));
    send_fraction(clamp_frac(longint'(prob_a_q)));
    send_fraction(clamp_frac(thr_ab - 1));
    send_fraction(clamp_frac(thr_ab));
    send_fraction(clamp_frac(thr_abc - 1));
    send_fraction(clamp_frac(thr_abc));
    send_fraction($urandom);
  endtask

  // Single-level edges under each spatial boundary; levels of zero acts as one
  task automatic test_single_level_kinds();
    logic [PROB_W-1:0] quarter;
    quarter = 33'h0_4000_0000;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0: apply_settings(quarter, quarter, quarter, 5'd0, 21'd1);
        1: apply_settings(quarter, quarter, quarter, 5'd1, 21'd0);
        default: apply_settings(quarter, quarter, quarter, 5'd1, 21'h1F_FFFF);
      endcase
      send_fraction(32'h4000_0000);
      send_fraction(32'h8000_0000);
      if (k == 0) begin
        send_fraction(32'h0000_0000);
        send_fraction(32'hFFFF_FFFF);
      end
    end
  endtask

  // Lower the depth while an edge is half built
  task automatic test_depth_lowered_mid_edge();
    apply_settings(33'd2448131359, 33'd816043786, 33'd816043786, 5'd3, 21'd4);
    send_fraction($urandom);
    send_fraction($urandom);
    wait_for_drain();
    write_reg(CFG_LEVELS, 5'd1);
    send_fraction(32'hFFFF_FFFF);
    send_fraction($urandom);
  endtask

  // Thresholds at and beyond one, and overlapping thresholds
  task automatic test_oversized_thresholds();
    apply_settings(33'h1_0000_0000, 33'd0, 33'd0, 5'd1, 21'd1);
    send_fraction(32'hFFFF_FFFF);
    apply_settings(33'd0, 33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF, 5'd1, 21'd1);
    send_fraction($urandom);
    apply_settings(33'd0, 33'd0, 33'h1_FFFF_FFFF, 5'd1, 21'd1);
    send_fraction($urandom);
    apply_settings(33'd0, 33'd0, 33'd0, 5'd1, 21'd1);
    send_fraction(32'h0000_0000);
    apply_settings(33'h1_FFFF_FFFF, 33'd0, 33'd0, 5'd1, 21'd1);
    send_fraction(32'hFFFF_FFFF);
  endtask

  // A write to an index outside the map must leave every register alone
  task automatic test_unused_index();
    apply_settings(33'h0_4000_0000, 33'h0_4000_0000, 33'h0_4000_0000, 5'd2, 21'd2);
    write_reg(CFG_UNUSED, '1);
    send_fraction(32'h4000_0000);
    send_fraction(32'h8000_0000);
  endtask

  function automatic logic [PROB_W-1:0] pick_prob(input int style);
    case (style)
      0: return 33'($urandom_range(0, 32'h6000_0000));
      1: begin
        case ($urandom_range(0, 2))
          0: return 33'd0;
          1: return 33'h1_0000_0000;
          default: return 33'h1_FFFF_FFFF;
        endcase
      end
      default: return {1'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Random settings per phase, random fractions within each phase
  task automatic test_random_phases();
    int roll;
    int style;
    int count;
    int depth;
    logic [LEVELS_W-1:0]  lv;
    logic [SPATIAL_W-1:0] sp;
    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      lv = 5'($urandom_range(1, 3));
      else if (roll < 75) lv = 5'($urandom_range(4, 6));
      else if (roll < 80) lv = 5'd0;
      else if (roll < 85) lv = 5'd20;
      else if (roll < 90) lv = 5'd31;
      else                lv = 5'($urandom_range(7, 12));
      depth = (lv == 0) ? 1 : ((lv > NODE_BITS) ? NODE_BITS : int'(lv));
      roll = $urandom_range(0, 9);
      if (roll < 2)      sp = '0;
      else if (roll < 3) sp = 21'h1F_FFFF;
      else               sp = 21'($urandom_range(0, 1 << depth));
      roll  = $urandom_range(0, 19);
      style = (roll < 13) ? 0 : ((roll < 16) ? 1 : 2);
      apply_settings(pick_prob(style), pick_prob(style), pick_prob(style), lv, sp);
      count = (depth > 8) ? $urandom_range(2 * depth, 3 * depth) : $urandom_range(20, 60);
      for (int n = 0; n < count; n++) begin
        // Now and then hold the sender until everything has drained
        if ($urandom_range(0, 49) == 0) wait_for_drain();
        send_fraction(random_fraction());
        random_sent++;
      end
    end
  endtask

  // Receiver: always ready, a rotating stall mask, or random stalls
  initial begin
    out_ch.ready = 1'b0;
    rx_mode = 0;
    rx_hold = 0;
    rx_mask = 8'hFF;
    forever begin
      @(negedge clk);
      if (rx_hold == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_hold = $urandom_range(20, 120);
        rx_mask = 8'($urandom) | 8'h01;
      end
      rx_hold--;
      case (rx_mode)
        0: out_ch.ready = 1'b1;
        1: begin
          out_ch.ready = rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[7:1]};
        end
        default: out_ch.ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each accepted entry with the oldest one predicted
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_entry.src  = out_ch.src_node;
      got_entry.dst  = out_ch.dst_node;
      got_entry.kind = out_ch.edge_kind;
      got_entry.last = out_ch.last;
      if (entries_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected entry src %0d dst %0d kind %0d last %0d",
                                got_entry.src, got_entry.dst, got_entry.kind, got_entry.last));
      end else begin
        want_entry = entries_due.pop_front();
        if (got_entry.src !== want_entry.src || got_entry.dst !== want_entry.dst ||
            got_entry.kind !== want_entry.kind || got_entry.last !== want_entry.last) begin
          flag_mismatch($sformatf(
            "entry mismatch: expected src %0d dst %0d kind %0d last %0d, got %0d %0d %0d %0d",
            want_entry.src, want_entry.dst, want_entry.kind, want_entry.last,
            got_entry.src, got_entry.dst, got_entry.kind, got_entry.last));
        end
      end
    end
  end

  // Stop the run when no handshake completes for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.rand_fraction = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_PROB_A;
    cfg_ch.data         = '0;
    idle_cycles         = 0;
    mismatches          = 0;
    burst_left          = 0;
    random_sent         = 0;
    // Register defaults and a cleared walk, as after reset
    prob_a_q   = 33'd2448131359;
    prob_b_q   = 33'd816043786;
    prob_c_q   = 33'd816043786;
    levels_q   = 5'd20;
    spatial_q  = 21'd524288;
    walk_level = '0;
    walk_row   = '0;
    walk_col   = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_threshold_boundaries();
    test_single_level_kinds();
    test_depth_lowered_mid_edge();
    test_oversized_thresholds();
    test_unused_index();
    test_random_phases();

    wait_for_drain();
    if (entries_due.size() != 0) begin
      flag_mismatch($sformatf("%0d entries never arrived", entries_due.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
